### hdl/slmd_pkg.sv
// ----------------------------------------------------------------------------
// slmd_pkg
// Shared types and constants for the sync/length message deframer.
// ----------------------------------------------------------------------------
package slmd_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_SYNC_FIRST     = 3'd0;
    localparam logic [2:0] REG_SYNC_SECOND    = 3'd1;
    localparam logic [2:0] REG_SYNC_THIRD     = 3'd2;
    localparam logic [2:0] REG_TRAILER_LEN    = 3'd3;
    localparam logic [2:0] REG_MIN_HEADER_LEN = 3'd4;

    // reset values of the registers
    localparam logic [7:0] SYNC_FIRST_RST     = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST    = 8'h44;
    localparam logic [7:0] SYNC_THIRD_RST     = 8'h12;
    localparam logic [3:0] TRAILER_LEN_RST    = 4'd4;
    localparam logic [7:0] MIN_HEADER_LEN_RST = 8'd10;

    // frame byte positions, counted from the first sync byte
    localparam logic [16:0] POS_HLEN   = 17'd3;
    localparam logic [16:0] POS_LEN_LO = 17'd8;
    localparam logic [16:0] POS_LEN_HI = 17'd9;

    // result queue depth and room needed for a sync burst
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int MAX_BURST = 3;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] sync_third;
        logic [3:0] trailer_len;
        logic [7:0] min_header_len;
    } slmd_cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_start;
        logic       frame_last;
        logic       frame_error;
        logic       burst_last;
    } slmd_res_t;

endpackage

### hdl/slmd_core.sv
// ----------------------------------------------------------------------------
// slmd_core
// Frame state and per-byte decode: sync hunt, length capture, end of frame.
// ----------------------------------------------------------------------------
module slmd_core
    import slmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  slmd_cfg_t  cfg,
    input  logic       fire,
    input  logic [7:0] in_byte,
    output logic [1:0] res_n,
    output slmd_res_t  res [MAX_BURST]
);

    logic [15:0] hist_reg, hist_next;
    logic        in_frame_reg, in_frame_next;
    logic [16:0] count_reg, count_next;
    logic [7:0]  hlen_reg, hlen_next;
    logic [15:0] body_reg, body_next;
    logic [16:0] total_reg, total_next;

    logic        match;
    logic [17:0] pos_inc;
    logic        last;

    // sync pattern over history plus the current byte
    assign match = (count_reg >= 17'd2) && (hist_reg[15:8] == cfg.sync_first) &&
                   (hist_reg[7:0] == cfg.sync_second) && (in_byte == cfg.sync_third);

    assign pos_inc = {1'b0, count_reg} + 18'd1;

    // next state and results for one item
    always_comb begin
        hist_next     = hist_reg;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        hlen_next     = hlen_reg;
        body_next     = body_reg;
        total_next    = total_reg;
        last          = 1'b0;
        res_n         = 2'd0;
        for (int k = 0; k < MAX_BURST; k++) begin
            res[k] = '0;
        end
        res[0].out_byte = in_byte;

        if (!in_frame_reg) begin
            if (match) begin
                res_n              = 2'd3;
                res[0].out_byte    = hist_reg[15:8];
                res[0].frame_start = 1'b1;
                res[1].out_byte    = hist_reg[7:0];
                res[2].out_byte    = in_byte;
                res[2].burst_last  = 1'b1;
                in_frame_next      = 1'b1;
                count_next         = 17'd3;
                hist_next          = '0;
                hlen_next          = '0;
                body_next          = '0;
                total_next         = '0;
            end else begin
                hist_next = {hist_reg[7:0], in_byte};
                if (count_reg < 17'd2) begin
                    count_next = count_reg + 17'd1;
                end
            end
        end else begin
            res_n             = 2'd1;
            res[0].burst_last = 1'b1;
            if (count_reg == POS_HLEN && in_byte < cfg.min_header_len) begin
                // short header aborts the frame
                hlen_next          = in_byte;
                res[0].frame_last  = 1'b1;
                res[0].frame_error = 1'b1;
                in_frame_next      = 1'b0;
                hist_next          = '0;
                count_next         = '0;
            end else begin
                if (count_reg == POS_HLEN) begin
                    hlen_next = in_byte;
                end
                if (count_reg == POS_LEN_LO) begin
                    body_next = {body_reg[15:8], in_byte};
                end
                if (count_reg == POS_LEN_HI) begin
                    body_next  = {in_byte, body_reg[7:0]};
                    total_next = {9'd0, hlen_reg} + {1'b0, in_byte, body_reg[7:0]} +
                                 {13'd0, cfg.trailer_len};
                end
                last = (count_reg >= POS_LEN_HI) && ({1'b0, total_next} <= pos_inc);
                res[0].frame_last = last;
                if (last) begin
                    in_frame_next = 1'b0;
                    hist_next     = '0;
                    count_next    = '0;
                end else begin
                    count_next = pos_inc[16:0];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg     <= '0;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            hlen_reg     <= '0;
            body_reg     <= '0;
            total_reg    <= '0;
        end else if (fire) begin
            hist_reg     <= hist_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            hlen_reg     <= hlen_next;
            body_reg     <= body_next;
            total_reg    <= total_next;
        end
    end

`ifndef SYNTHESIS
    // a sync burst opens the frame and closes the burst on its third result
    a_burst_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_n == 2'd3) |->
            (res[0].frame_start && !res[0].burst_last && res[2].burst_last))
        else $error("sync burst badly formed");

    // inside a frame every byte gives exactly one result
    a_frame_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_frame_reg) |-> (res_n == 2'd1 && res[0].burst_last))
        else $error("in-frame byte did not give one result");

    // an error always closes the frame and returns to hunting
    a_err_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_n == 2'd1 && res[0].frame_error) |=> (!in_frame_reg && count_reg == '0))
        else $error("aborted frame did not resume hunting");
`endif

endmodule

### hdl/slmd_outq.sv
// ----------------------------------------------------------------------------
// slmd_outq
// Four-entry result queue; takes up to three results in one cycle.
// ----------------------------------------------------------------------------
module slmd_outq
    import slmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  slmd_res_t  push_res [MAX_BURST],
    output logic       room,
    output logic       pop_valid,
    input  logic       pop_ready,
    output slmd_res_t  pop_res
);

    slmd_res_t        mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg, count_next;
    logic             pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_res   = mem[rd_ptr_reg];
    // room for a full burst before any pop of this cycle
    assign room      = (count_reg <= (QAW+1)'(QDEPTH - MAX_BURST));

    assign count_next = count_reg + {1'b0, push_n} - {{QAW{1'b0}}, pop};

    // entry storage
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_BURST; k++) begin
            if (k < int'(push_n)) begin
                mem[wr_ptr_reg + QAW'(k)] <= push_res[k];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // the queue never overfills
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    // results are only pushed when a full burst fits
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0) |-> room)
        else $error("push without room");
`endif

endmodule

### hdl/sync_length_message_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_message_deframer
// Byte stream deframer: sync hunt, header/body length tracking, end marking.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the s_ channel and returns frame bytes on the
// m_ channel. Bytes are registered on input, decoded once the result queue
// has room, and written to a four-entry result queue, whose registered head
// drives the m_ channel. Hunting bytes give no result; a byte that completes
// the sync pattern gives three results, and each frame byte gives one.
// Input throughput is one byte per cycle while the consumer keeps up; after
// a sync burst the input stalls while the queue drains, since a byte is only
// decoded when the queue has room for three. Configuration writes are always
// accepted (cfg_ready is tied high); indexes beyond the register list are
// ignored.
// ----------------------------------------------------------------------------
module sync_length_message_deframer
    import slmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    // frame output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_start,
    output logic       m_frame_last,
    output logic       m_frame_error,
    output logic       m_burst_last
);

    slmd_cfg_t  cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       fire;
    logic [1:0] res_n;
    logic [1:0] push_n;
    slmd_res_t  res [MAX_BURST];
    slmd_res_t  pop_res;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first     <= SYNC_FIRST_RST;
            cfg_reg.sync_second    <= SYNC_SECOND_RST;
            cfg_reg.sync_third     <= SYNC_THIRD_RST;
            cfg_reg.trailer_len    <= TRAILER_LEN_RST;
            cfg_reg.min_header_len <= MIN_HEADER_LEN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_FIRST:     cfg_reg.sync_first     <= cfg_data;
                REG_SYNC_SECOND:    cfg_reg.sync_second    <= cfg_data;
                REG_SYNC_THIRD:     cfg_reg.sync_third     <= cfg_data;
                REG_TRAILER_LEN:    cfg_reg.trailer_len    <= cfg_data[3:0];
                REG_MIN_HEADER_LEN: cfg_reg.min_header_len <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // decode
    slmd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .res_n   (res_n),
        .res     (res)
    );

    assign push_n = fire ? res_n : 2'd0;

    // result queue
    slmd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_res  (res),
        .room      (room),
        .pop_valid (m_valid),
        .pop_ready (m_ready),
        .pop_res   (pop_res)
    );

    assign m_out_byte    = pop_res.out_byte;
    assign m_frame_start = pop_res.frame_start;
    assign m_frame_last  = pop_res.frame_last;
    assign m_frame_error = pop_res.frame_error;
    assign m_burst_last  = pop_res.burst_last;

`ifndef SYNTHESIS
    // a held input byte is decoded as soon as the queue has room
    a_input_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && room) |-> fire)
        else $error("input byte not decoded despite room");
`endif

endmodule

### tb/slmd_deframe_checker.sv
// ----------------------------------------------------------------------------
// slmd_deframe_checker
// Watches the deframer's channels, predicts each frame byte and compares.
// ----------------------------------------------------------------------------
// Keeps its own copy of the registers and of the hunt/frame state. Every
// accepted input item is run through the predictor, and the results it
// should give are queued. Every accepted result item is checked field by
// field against the oldest queued one. The number of results still due
// and the failure count are handed to the testbench top.
// ----------------------------------------------------------------------------
module slmd_deframe_checker
    import slmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_frame_start,
    input  logic       m_frame_last,
    input  logic       m_frame_error,
    input  logic       m_burst_last,
    output int         n_due,
    output int         n_fail
);

    // shadow registers and predictor state
    slmd_cfg_t   regs;
    logic [15:0] hunt_hist;
    logic        in_frame;
    logic [16:0] frame_pos;
    logic [7:0]  hdr_len;
    logic [15:0] body_len;
    logic [16:0] frame_total;

    // results predicted but not yet seen on the m_ channel
    slmd_res_t   frame_bytes_due[$];

    initial begin
        n_due  = 0;
        n_fail = 0;
    end

    // one line per bad result
    task automatic report_mismatch(input string msg);
        $display("checker: mismatch at %0t: %s", $time, msg);
        n_fail++;
    endtask

    task automatic queue_result(input logic [7:0] b, input logic st, input logic ls,
                                input logic er, input logic bl);
        slmd_res_t r;
        r.out_byte    = b;
        r.frame_start = st;
        r.frame_last  = ls;
        r.frame_error = er;
        r.burst_last  = bl;
        frame_bytes_due.push_back(r);
    endtask

    task automatic resume_hunt();
        in_frame  = 1'b0;
        hunt_hist = '0;
        frame_pos = '0;
    endtask

    // predict what one received byte gives
    task automatic deframe_byte(input logic [7:0] b);
        logic ends;
        ends = 1'b0;
        if (!in_frame) begin
            // hunting: frame_pos counts valid history bytes
            if (frame_pos >= 17'd2 && hunt_hist[15:8] == regs.sync_first &&
                    hunt_hist[7:0] == regs.sync_second && b == regs.sync_third) begin
                queue_result(hunt_hist[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
                queue_result(hunt_hist[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
                queue_result(b, 1'b0, 1'b0, 1'b0, 1'b1);
                in_frame    = 1'b1;
                frame_pos   = 17'd3;
                hunt_hist   = '0;
                hdr_len     = '0;
                body_len    = '0;
                frame_total = '0;
            end else begin
                hunt_hist = {hunt_hist[7:0], b};
                if (frame_pos < 17'd2)
                    frame_pos = frame_pos + 17'd1;
            end
        end else if (frame_pos == POS_HLEN && b < regs.min_header_len) begin
            // header too short, abort and hunt again
            hdr_len = b;
            queue_result(b, 1'b0, 1'b1, 1'b1, 1'b1);
            resume_hunt();
        end else begin
            case (frame_pos)
                POS_HLEN:   hdr_len = b;
                POS_LEN_LO: body_len[7:0] = b;
                POS_LEN_HI: begin
                    body_len[15:8] = b;
                    frame_total = {9'd0, hdr_len} + {1'b0, body_len}
                                + {13'd0, regs.trailer_len};
                end
                default: ;
            endcase
            ends = (frame_pos >= POS_LEN_HI) && (frame_total <= frame_pos + 17'd1);
            queue_result(b, 1'b0, ends, 1'b0, 1'b1);
            if (ends)
                resume_hunt();
            else
                frame_pos = frame_pos + 17'd1;
        end
    endtask

    // sample both channels at each edge
    always @(posedge aclk) begin
        slmd_res_t want;
        if (!aresetn) begin
            regs.sync_first     = SYNC_FIRST_RST;
            regs.sync_second    = SYNC_SECOND_RST;
            regs.sync_third     = SYNC_THIRD_RST;
            regs.trailer_len    = TRAILER_LEN_RST;
            regs.min_header_len = MIN_HEADER_LEN_RST;
            hunt_hist   = '0;
            in_frame    = 1'b0;
            frame_pos   = '0;
            hdr_len     = '0;
            body_len    = '0;
            frame_total = '0;
            frame_bytes_due.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SYNC_FIRST:     regs.sync_first     = cfg_data;
                    REG_SYNC_SECOND:    regs.sync_second    = cfg_data;
                    REG_SYNC_THIRD:     regs.sync_third     = cfg_data;
                    REG_TRAILER_LEN:    regs.trailer_len    = cfg_data[3:0];
                    REG_MIN_HEADER_LEN: regs.min_header_len = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                deframe_byte(s_in_byte);
            // compare result item with the oldest prediction
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("result %02h with nothing due", m_out_byte));
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_out_byte !== want.out_byte || m_frame_start !== want.frame_start ||
                            m_frame_last !== want.frame_last ||
                            m_frame_error !== want.frame_error ||
                            m_burst_last !== want.burst_last)
                        report_mismatch($sformatf(
                            "got %02h s%b l%b e%b b%b, want %02h s%b l%b e%b b%b",
                            m_out_byte, m_frame_start, m_frame_last, m_frame_error,
                            m_burst_last, want.out_byte, want.frame_start,
                            want.frame_last, want.frame_error, want.burst_last));
                end
            end
        end
        n_due <= frame_bytes_due.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sync/length message deframer.
// ----------------------------------------------------------------------------
// Drives a short hand-made byte stream at the reset settings, then random
// traffic under several register settings: mostly well-formed frames with
// random content, mixed with noise, broken sync patterns and short headers.
// Both sides stall in random bursts except in the last part. Checking is
// done by slmd_deframe_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import slmd_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 8;    // input register and result queue, with margin
    localparam int         TAIL_CYCLES  = 20;
    localparam logic [2:0] REG_UNUSED   = 3'd5;

    // hand-made opening, first byte in the top bits
    localparam int OPENING_LEN = 23;
    localparam logic [OPENING_LEN*8-1:0] OPENING = {
        8'hFF, 8'h00,
        SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST,  // overlapped sync
        8'h05,                                                            // short header
        SYNC_THIRD_RST,                                                   // lone sync byte
        SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST, 8'd10,
        8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h00, 8'h80, 8'h7F,
        SYNC_FIRST_RST, SYNC_SECOND_RST,                                  // frame tail
        SYNC_THIRD_RST                                                    // must not sync
    };

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = REG_SYNC_FIRST;
    logic [7:0] cfg_data  = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_frame_start;
    logic       m_frame_last;
    logic       m_frame_error;
    logic       m_burst_last;

    int         n_due;
    int         n_fail;
    int         cycle_cnt  = 0;
    int         stall_left = 0;
    bit         idle_on    = 1'b1;
    slmd_cfg_t  cfg_now;

    sync_length_message_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_start (m_frame_start),
        .m_frame_last  (m_frame_last),
        .m_frame_error (m_frame_error),
        .m_burst_last  (m_burst_last)
    );

    slmd_deframe_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_start (m_frame_start),
        .m_frame_last  (m_frame_last),
        .m_frame_error (m_frame_error),
        .m_burst_last  (m_burst_last),
        .n_due         (n_due),
        .n_fail        (n_fail)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver stalls in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // offer one byte, with an occasional gap before it
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop input, wait for every due result, then let the pipeline empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (n_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_config(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] s3, input logic [3:0] trl,
                               input logic [7:0] minh);
        logic [3:0] junk_hi;
        logic [7:0] junk;
        junk_hi = $urandom_range(0, 15);
        junk    = $urandom;
        wait_idle();
        write_reg(REG_SYNC_FIRST, s1);
        write_reg(REG_SYNC_SECOND, s2);
        write_reg(REG_SYNC_THIRD, s3);
        // upper bits of the trailer write are don't-care
        write_reg(REG_TRAILER_LEN, {junk_hi, trl});
        write_reg(REG_MIN_HEADER_LEN, minh);
        write_reg(REG_UNUSED, junk);
        cfg_valid <= 1'b0;
        cfg_now.sync_first     = s1;
        cfg_now.sync_second    = s2;
        cfg_now.sync_third     = s3;
        cfg_now.trailer_len    = trl;
        cfg_now.min_header_len = minh;
    endtask

    // one well-formed frame with random filler
    task automatic send_frame(input int hl, input int bl, inout int sent);
        int         total;
        int         p;
        logic [7:0] b;
        total = hl + bl + cfg_now.trailer_len;
        if (total < 10)
            total = 10;
        for (p = 0; p < total; p++) begin
            if (p == 0)
                b = cfg_now.sync_first;
            else if (p == 1)
                b = cfg_now.sync_second;
            else if (p == 2)
                b = cfg_now.sync_third;
            else if (p == POS_HLEN)
                b = hl[7:0];
            else if (p == POS_LEN_LO)
                b = bl[7:0];
            else if (p == POS_LEN_HI)
                b = bl[15:8];
            else
                b = $urandom;
            send_byte(b);
        end
        sent += total;
    endtask

    // mostly frames, some noise, broken syncs and short headers
    task automatic random_phase(input int goal);
        int         sent;
        int         kind;
        int         hl;
        int         bl;
        int         top_hl;
        logic [7:0] b;
        sent = 0;
        while (sent < goal) begin
            kind   = $urandom_range(0, 9);
            top_hl = cfg_now.min_header_len + 12;
            if (top_hl > 255)
                top_hl = 255;
            if (kind <= 6) begin
                // false start ahead of the frame, unless it would shift the sync
                if (kind == 6 && !(cfg_now.sync_first == cfg_now.sync_second &&
                                   cfg_now.sync_second == cfg_now.sync_third)) begin
                    send_byte(cfg_now.sync_first);
                    sent += 1;
                end
                hl = ($urandom_range(0, 19) == 0) ? 255
                   : $urandom_range(cfg_now.min_header_len, top_hl);
                if ($urandom_range(0, 24) == 0)
                    bl = 256 + $urandom_range(0, 30);
                else if ($urandom_range(0, 3) == 0)
                    bl = 0;
                else
                    bl = $urandom_range(0, 24);
                send_frame(hl, bl, sent);
            end else if (kind == 7) begin
                // noise, never the closing sync byte
                repeat ($urandom_range(1, 6)) begin
                    do begin
                        if ($urandom_range(0, 2) == 0)
                            b = $urandom_range(0, 1) ? cfg_now.sync_first : cfg_now.sync_second;
                        else
                            b = $urandom;
                    end while (b == cfg_now.sync_third);
                    send_byte(b);
                    sent += 1;
                end
            end else if (kind == 8) begin
                // sync pattern broken at its third byte
                send_byte(cfg_now.sync_first);
                send_byte(cfg_now.sync_second);
                do b = $urandom; while (b == cfg_now.sync_third);
                send_byte(b);
                sent += 3;
            end else begin
                // header length below the minimum
                send_byte(cfg_now.sync_first);
                send_byte(cfg_now.sync_second);
                send_byte(cfg_now.sync_third);
                hl = ($urandom_range(0, 1) == 0) ? cfg_now.min_header_len - 1
                   : $urandom_range(0, cfg_now.min_header_len - 1);
                send_byte(hl[7:0]);
                sent += 4;
            end
        end
    endtask

    // main sequence
    initial begin
        int i;
        cfg_now.sync_first     = SYNC_FIRST_RST;
        cfg_now.sync_second    = SYNC_SECOND_RST;
        cfg_now.sync_third     = SYNC_THIRD_RST;
        cfg_now.trailer_len    = TRAILER_LEN_RST;
        cfg_now.min_header_len = MIN_HEADER_LEN_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-made opening at reset settings
        for (i = OPENING_LEN - 1; i >= 0; i--)
            send_byte(OPENING[i*8 +: 8]);

        // extremes: longest trailer, then all-zero sync and no trailer
        load_config(8'hFF, 8'h00, 8'hFF, 4'd15, 8'd30);
        random_phase(10);
        load_config(8'h00, 8'h00, 8'h00, 4'd0, 8'd10);
        random_phase(25);
        load_config($urandom, $urandom, $urandom, $urandom_range(0, 15),
                    $urandom_range(10, 60));
        random_phase(25);

        // back to reset settings, no stalls on either side
        load_config(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST, TRAILER_LEN_RST,
                    MIN_HEADER_LEN_RST);
        idle_on = 1'b0;
        random_phase(25);

        s_valid <= 1'b0;
        do @(posedge aclk); while (n_due != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_fail == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
